// File: src/bounded_stack_with_search_core_defines.svh
// assertion macros used by the stack controller
`ifndef BOUNDED_STACK_WITH_SEARCH_CORE_DEFINES_SVH
`define BOUNDED_STACK_WITH_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BSWS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("stack check failed");

// next-cycle implication, checked outside reset
`define BSWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("stack check failed");

`endif

// File: src/bsws_pkg.sv
`timescale 1ns / 1ps

package bsws_pkg;

    localparam int DEFAULT_STACK_DEPTH = 256;
    localparam int DATA_W              = 32;

    localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

    // requested operation of one item
    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_SEARCH
    } t_state;

    // memory port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // one result item
    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic                     pop_was_empty;
        logic                     found;
        logic signed [DATA_W-1:0] top_value;
        logic                     is_empty;
        logic                     overflow;
    } t_result;

endpackage

// File: src/bounded_stack_with_search_core.sv
`timescale 1ns / 1ps
// lifo stack of signed 32-bit values with a membership search
// input channel: i_in_valid / o_in_ready carry one item (i_action, i_value):
//   push, pop, search or clear
// output channel: o_out_valid / i_out_ready carry one result item per input item
// push, clear, an empty pop and a pop of the last entry send their result to the
//   output register from the accepting cycle; any other pop first reads the entry
//   below the old top through the registered read port of the entry memory (ST_POP_RD)
// a search on n stored entries walks them from the top, one memory read per cycle,
//   and ends at the first match or after the bottom entry
// throughput: one item per cycle for push and clear while i_out_ready stays high; one
//   item at a time otherwise, the next item is taken once the previous one has its result
// a result waits in the output register while the receiver stalls; the next item
//   is accepted in the same cycle the waiting result is taken
// reset (synchronous, active low) empties the stack at once; entry memory keeps
//   stale contents that are never read before being written again
module bounded_stack_with_search_core
    import bsws_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_action,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic                     o_pop_was_empty,
    output logic                     o_found,
    output logic signed [DATA_W-1:0] o_top_value,
    output logic                     o_is_empty,
    output logic                     o_overflow
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);

    t_mem_ctl                 mem_ctl;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ADDR_W-1:0]        mem_raddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic signed [DATA_W-1:0] mem_rdata;
    logic                     res_valid;
    t_result                  res;
    logic                     out_free;

    logic                     r_out_valid;
    t_result                  r_out;

    assign out_free = !r_out_valid || i_out_ready;

    bsws_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_ctl   (mem_ctl),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    bsws_ram #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_popped_value  = r_out.popped_value;
    assign o_pop_was_empty = r_out.pop_was_empty;
    assign o_found         = r_out.found;
    assign o_top_value     = r_out.top_value;
    assign o_is_empty      = r_out.is_empty;
    assign o_overflow      = r_out.overflow;

endmodule

// File: src/bsws_ram.sv
`timescale 1ns / 1ps

module bsws_ram
    import bsws_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
    localparam int ADDR_W     = $clog2(STACK_DEPTH)
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]        i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bsws_ctrl.sv
`timescale 1ns / 1ps
`include "bounded_stack_with_search_core_defines.svh"

module bsws_ctrl
    import bsws_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
    localparam int ADDR_W     = $clog2(STACK_DEPTH),
    localparam int FILL_W     = $clog2(STACK_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input item side
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_action,
    input  logic signed [DATA_W-1:0] i_value,
    // result slot
    input  logic                     i_out_free,
    output logic                     o_res_valid,
    output t_result                  o_res,
    // memory port
    output t_mem_ctl                 o_mem_ctl,
    output logic [ADDR_W-1:0]        o_waddr,
    output logic signed [DATA_W-1:0] o_wdata,
    output logic [ADDR_W-1:0]        o_raddr,
    input  logic signed [DATA_W-1:0] i_rdata
);

    t_state                   r_state, n_state;
    logic [FILL_W-1:0]        r_fill, n_fill;
    logic signed [DATA_W-1:0] r_top, n_top;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic signed [DATA_W-1:0] r_popped, n_popped;
    logic [ADDR_W-1:0]        r_idx, n_idx;

    logic              accept;
    t_action           action;
    logic              is_empty_now;
    logic              is_full_now;
    logic [FILL_W-1:0] fill_m1;
    logic [FILL_W-1:0] fill_m2;
    logic              hit;
    logic              search_done;

    assign o_in_ready   = (r_state == ST_IDLE) && i_out_free;
    assign accept       = i_in_valid && o_in_ready;
    assign action       = t_action'(i_action);
    assign is_empty_now = (r_fill == '0);
    assign is_full_now  = (r_fill == FILL_W'(STACK_DEPTH));
    assign fill_m1      = r_fill - FILL_W'(1);
    assign fill_m2      = r_fill - FILL_W'(2);
    assign hit          = (i_rdata == r_key);
    assign search_done  = hit || (r_idx == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (action)
                        ACT_POP: begin
                            if (!is_empty_now && (fill_m1 != '0)) begin
                                n_state = ST_POP_RD;
                            end
                        end
                        ACT_SEARCH: begin
                            if (!is_empty_now) begin
                                n_state = ST_SEARCH;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP_RD: begin
                n_state = ST_IDLE;
            end
            ST_SEARCH: begin
                if (search_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath, memory strobes and result
    always_comb begin
        o_mem_ctl   = '0;
        o_waddr     = r_fill[ADDR_W-1:0];
        o_wdata     = i_value;
        o_raddr     = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.top_value = is_empty_now ? NEG_ONE : r_top;
        o_res.is_empty  = is_empty_now;
        n_fill      = r_fill;
        n_top       = r_top;
        n_key       = r_key;
        n_popped    = r_popped;
        n_idx       = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (action)
                        ACT_PUSH: begin
                            o_res_valid = 1'b1;
                            if (is_full_now) begin
                                o_res.overflow = 1'b1;
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                n_fill          = r_fill + FILL_W'(1);
                                n_top           = i_value;
                                o_res.top_value = i_value;
                                o_res.is_empty  = 1'b0;
                            end
                        end
                        ACT_POP: begin
                            if (is_empty_now) begin
                                o_res_valid         = 1'b1;
                                o_res.popped_value  = NEG_ONE;
                                o_res.pop_was_empty = 1'b1;
                            end else begin
                                n_fill   = fill_m1;
                                n_popped = r_top;
                                if (fill_m1 == '0) begin
                                    // last entry leaves
                                    o_res_valid        = 1'b1;
                                    o_res.popped_value = r_top;
                                    o_res.top_value    = NEG_ONE;
                                    o_res.is_empty     = 1'b1;
                                end else begin
                                    // fetch the entry below as the new top
                                    o_mem_ctl.rd_en = 1'b1;
                                    o_raddr         = fill_m2[ADDR_W-1:0];
                                end
                            end
                        end
                        ACT_SEARCH: begin
                            if (is_empty_now) begin
                                o_res_valid = 1'b1;
                            end else begin
                                // start the walk at the top entry
                                o_mem_ctl.rd_en = 1'b1;
                                o_raddr         = fill_m1[ADDR_W-1:0];
                                n_idx           = fill_m1[ADDR_W-1:0];
                                n_key           = i_value;
                            end
                        end
                        default: begin
                            // clear drops the count only
                            o_res_valid     = 1'b1;
                            n_fill          = '0;
                            o_res.top_value = NEG_ONE;
                            o_res.is_empty  = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_RD: begin
                o_res_valid        = 1'b1;
                n_top              = i_rdata;
                o_res.popped_value = r_popped;
                o_res.top_value    = i_rdata;
                o_res.is_empty     = 1'b0;
            end
            ST_SEARCH: begin
                // compare the entry read last cycle, fetch the next one down
                if (search_done) begin
                    o_res_valid = 1'b1;
                    o_res.found = hit;
                end else begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_raddr         = r_idx - ADDR_W'(1);
                    n_idx           = r_idx - ADDR_W'(1);
                end
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // working values
    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_key    <= n_key;
        r_popped <= n_popped;
        r_idx    <= n_idx;
    end

    // checks
    `BSWS_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(STACK_DEPTH))
    `BSWS_ASSERT_IMPL(a_no_rw_overlap, i_clk, i_rst_n, o_mem_ctl.wr_en, !o_mem_ctl.rd_en)
    `BSWS_ASSERT_IMPL(a_walk_in_range, i_clk, i_rst_n, r_state == ST_SEARCH, r_idx < r_fill)
    `BSWS_ASSERT_IMPL(a_result_has_slot, i_clk, i_rst_n, o_res_valid, i_out_free)
    `BSWS_ASSERT_NEXT(a_pop_read_nonempty, i_clk, i_rst_n, r_state == ST_POP_RD,
                      r_state == ST_IDLE && r_fill != '0)

endmodule
